// ===== rtl/barometric_pressure_compensation_macros.svh =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation assertion macros
// Shared assertion wrappers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define BPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation package
// Widths, register indexes, constants and stage payload types.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMPO_W = 19;
  localparam int PRES_W  = 32;
  localparam int IDX_W   = 3;

  // internal widths
  localparam int DT_W    = 25;  // D2 - C5*256
  localparam int MUL_W   = 42;  // dT times a coefficient
  localparam int SQ_W    = 50;  // dT squared
  localparam int DTC_W   = 19;  // TEMP - 2000
  localparam int TEMP_W  = 20;
  localparam int T2_W    = 18;
  localparam int OFF1_W  = 36;  // first-order OFF / SENS
  localparam int F_W     = 36;  // squared temperature terms
  localparam int COR_W   = 40;  // OFF2 / SENS2
  localparam int OFF_W   = 41;  // corrected OFF / SENS
  localparam int SLO_W   = 21;  // low split of SENS for the product
  localparam int SHI_W   = OFF_W - SLO_W;
  localparam int PP_W    = 45;  // partial products
  localparam int Q_W     = 46;
  localparam int DIFF_W  = 48;

  // pipeline depth, input transfer to result strobe
  localparam int LATENCY = 7;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SENS_COEFF    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_COEFF  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
  localparam logic [IDX_W-1:0] REG_REF_TEMP      = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_SENS     = 3'd5;

  // temperature constants
  localparam logic signed [TEMP_W-1:0] TEMP_BASE    = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] VCOLD_OFFSET = 20'sd3500;  // 2000 + 1500

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic [RAW_W-1:0]       d1;
    logic signed [DT_W-1:0] dt;
  } s1_t;

  typedef struct packed {
    logic [RAW_W-1:0]        d1;
    logic signed [MUL_W-1:0] mt;
    logic signed [MUL_W-1:0] mo;
    logic signed [MUL_W-1:0] ms;
    logic signed [SQ_W-1:0]  mq;
  } s2_t;

  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [DTC_W-1:0]  dtc;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] dvc;
    logic signed [OFF1_W-1:0] off;
    logic signed [OFF1_W-1:0] sens;
    logic [T2_W-1:0]          t2;
  } s3_t;

  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF1_W-1:0] off;
    logic signed [OFF1_W-1:0] sens;
    logic [T2_W-1:0]          t2;
    logic                     cold;
    logic                     vcold;
    logic [F_W-1:0]           f1;
    logic [F_W-1:0]           f2;
  } s4_t;

  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [OFF_W-1:0]  sens;
  } s5_t;

endpackage

// ===== rtl/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Second-order temperature compensated pressure from raw D1/D2 conversions.
// ----------------------------------------------------------------------------
//  channel  ports                                        transfer
//  -------  -------------------------------------------  ----------------------
//  input    start, busy, in_raw_pressure,                start && !busy
//           in_raw_temperature
//  result   out_valid, out_temperature_centi,            out_valid, one cycle
//           out_pressure_pa
//  config   cfg_we, cfg_index, cfg_data                  cfg_we
//
//  Seven-stage pipeline: one item per cycle, result strobed from stage 7 for
//  its input transfer. Latency is set by the register stages around the
//  dT multipliers, the square terms and the split D1*SENS product.
//  busy stays low; the receiver cannot stall, so nothing ever backs up.
//  Reset clears the stage valid bits and the calibration words.
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_macros.svh"

module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [RAW_W-1:0]          in_raw_pressure,
  input  logic [RAW_W-1:0]          in_raw_temperature,
  output logic                      out_valid,
  output logic signed [TEMPO_W-1:0] out_temperature_centi,
  output logic signed [PRES_W-1:0]  out_pressure_pa,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]         cfg_data
);

  cal_t cal;
  logic in_xfer;
  logic vld3, vld5;
  s3_t  s3;
  s5_t  s5;

  // the pipeline takes an item every cycle
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  bpc_cal_regs u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  bpc_first_order u_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .cal     (cal),
    .in_vld  (in_xfer),
    .in_d1   (in_raw_pressure),
    .in_d2   (in_raw_temperature),
    .out_vld (vld3),
    .out_s3  (s3)
  );

  bpc_second_order u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld3),
    .in_s3   (s3),
    .out_vld (vld5),
    .out_s5  (s5)
  );

  bpc_pressure u_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld5),
    .in_s5    (s5),
    .out_vld  (out_valid),
    .out_temp (out_temperature_centi),
    .out_pres (out_pressure_pa)
  );

  // every result traces back to an earlier input transfer
  `BPC_ASSERT_IMP(a_result_has_source, clk, rst_n, out_valid, $past(in_xfer, LATENCY))

endmodule

// ===== rtl/bpc_cal_regs.sv =====
// ----------------------------------------------------------------------------
// Calibration register file
// Six 16-bit factory calibration words, written through the config port.
// ----------------------------------------------------------------------------
module bpc_cal_regs
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  output cal_t              cal
);

  cal_t cal_r;
  cal_t cal_nxt;

  // decode write; unused indexes are dropped
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SENS_COEFF:    cal_nxt.c1 = cfg_data;
        REG_OFFSET_COEFF:  cal_nxt.c2 = cfg_data;
        REG_SENS_TEMPCO:   cal_nxt.c3 = cfg_data;
        REG_OFFSET_TEMPCO: cal_nxt.c4 = cfg_data;
        REG_REF_TEMP:      cal_nxt.c5 = cfg_data;
        REG_TEMP_SENS:     cal_nxt.c6 = cfg_data;
        default:           cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

// ===== rtl/bpc_first_order.sv =====
// ----------------------------------------------------------------------------
// First-order compensation stages
// Stages 1-3: dT, the four dT products, then TEMP, OFF, SENS and T2.
// ----------------------------------------------------------------------------
module bpc_first_order
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cal_t             cal,
  input  logic             in_vld,
  input  logic [RAW_W-1:0] in_d1,
  input  logic [RAW_W-1:0] in_d2,
  output logic             out_vld,
  output s3_t              out_s3
);

  logic vld1_r, vld2_r, vld3_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;

  // stage 1: dT = D2 - C5*256
  always_comb begin
    s1_nxt.d1 = in_d1;
    s1_nxt.dt = $signed({1'b0, in_d2}) - $signed({1'b0, cal.c5, 8'd0});
  end

  // stage 2: dT products, one multiplier each
  always_comb begin
    s2_nxt.d1 = s1_r.d1;
    s2_nxt.mt = MUL_W'($signed(s1_r.dt)) * MUL_W'($signed({1'b0, cal.c6}));
    s2_nxt.mo = MUL_W'($signed(s1_r.dt)) * MUL_W'($signed({1'b0, cal.c4}));
    s2_nxt.ms = MUL_W'($signed(s1_r.dt)) * MUL_W'($signed({1'b0, cal.c3}));
    s2_nxt.mq = SQ_W'($signed(s1_r.dt)) * SQ_W'($signed(s1_r.dt));
  end

  // stage 3: shifts and base terms
  always_comb begin
    s3_nxt.d1   = s2_r.d1;
    s3_nxt.dtc  = $signed(s2_r.mt[MUL_W-1:23]);
    s3_nxt.temp = TEMP_W'($signed(s2_r.mt[MUL_W-1:23])) + TEMP_BASE;
    s3_nxt.dvc  = TEMP_W'($signed(s2_r.mt[MUL_W-1:23])) + VCOLD_OFFSET;
    s3_nxt.off  = $signed({4'd0, cal.c2, 16'd0})
                + OFF1_W'($signed(s2_r.mo[MUL_W-1:7]));
    s3_nxt.sens = $signed({5'd0, cal.c1, 15'd0})
                + OFF1_W'($signed(s2_r.ms[MUL_W-1:8]));
    s3_nxt.t2   = s2_r.mq[48:31];  // dT^2 is never negative
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  assign out_vld = vld3_r;
  assign out_s3  = s3_r;

endmodule

// ===== rtl/bpc_second_order.sv =====
// ----------------------------------------------------------------------------
// Second-order correction stages
// Stages 4-5: squared temperature terms, then cold corrections applied.
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_macros.svh"

module bpc_second_order
  import bpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  s3_t  in_s3,
  output logic out_vld,
  output s5_t  out_s5
);

  logic vld4_r, vld5_r;
  s4_t  s4_r, s4_nxt;
  s5_t  s5_r, s5_nxt;

  logic signed [37:0]  sq1;
  logic signed [39:0]  sq2;
  logic [38:0]         five_f1;
  logic [38:0]         seven_f2;
  logic [39:0]         eleven_f2;
  logic [COR_W-1:0]    off2;
  logic [COR_W-1:0]    sens2;

  // stage 4: cold flags and squares
  always_comb begin
    sq1 = 38'($signed(in_s3.dtc)) * 38'($signed(in_s3.dtc));
    sq2 = 40'($signed(in_s3.dvc)) * 40'($signed(in_s3.dvc));
    s4_nxt.d1    = in_s3.d1;
    s4_nxt.temp  = in_s3.temp;
    s4_nxt.off   = in_s3.off;
    s4_nxt.sens  = in_s3.sens;
    s4_nxt.t2    = in_s3.t2;
    s4_nxt.cold  = in_s3.dtc[DTC_W-1];   // TEMP < 2000
    s4_nxt.vcold = in_s3.dvc[TEMP_W-1];  // TEMP < -1500
    s4_nxt.f1    = sq1[F_W-1:0];
    s4_nxt.f2    = sq2[F_W-1:0];
  end

  // stage 5: OFF2 / SENS2 by shift-add, then subtract for cold items
  always_comb begin
    five_f1   = {3'd0, s4_r.f1} + {1'b0, s4_r.f1, 2'd0};
    seven_f2  = {s4_r.f2, 3'd0} - {3'd0, s4_r.f2};
    eleven_f2 = {1'b0, s4_r.f2, 3'd0} + {3'd0, s4_r.f2, 1'b0} + {4'd0, s4_r.f2};
    off2  = COR_W'(five_f1[38:1]);
    sens2 = COR_W'(five_f1[38:2]);
    if (s4_r.vcold) begin
      off2  = off2 + COR_W'(seven_f2);
      sens2 = sens2 + COR_W'(eleven_f2[39:1]);
    end
    s5_nxt.d1   = s4_r.d1;
    s5_nxt.temp = s4_r.temp;
    s5_nxt.off  = OFF_W'($signed(s4_r.off));
    s5_nxt.sens = OFF_W'($signed(s4_r.sens));
    if (s4_r.cold) begin
      s5_nxt.temp = s4_r.temp - $signed({2'd0, s4_r.t2});
      s5_nxt.off  = OFF_W'($signed(s4_r.off)) - $signed({1'b0, off2});
      s5_nxt.sens = OFF_W'($signed(s4_r.sens)) - $signed({1'b0, sens2});
    end
  end

  always_ff @(posedge clk) begin
    s4_r <= s4_nxt;
    s5_r <= s5_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld4_r <= in_vld;
      vld5_r <= vld4_r;
    end
  end

  assign out_vld = vld5_r;
  assign out_s5  = s5_r;

  // very cold is a subset of cold
  `BPC_ASSERT_IMP(a_vcold_in_cold, clk, rst_n, vld4_r && s4_r.vcold, s4_r.cold)
  // warm items pass OFF unchanged
  `BPC_ASSERT_NXT(a_warm_off_kept, clk, rst_n, vld4_r && !s4_r.cold,
                  s5_r.off == OFF_W'($signed($past(s4_r.off))))

endmodule

// ===== rtl/bpc_pressure.sv =====
// ----------------------------------------------------------------------------
// Pressure stages
// Stages 6-7: D1*SENS as two partial products, then shift, subtract OFF.
// ----------------------------------------------------------------------------
module bpc_pressure
  import bpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  s5_t                       in_s5,
  output logic                      out_vld,
  output logic signed [TEMPO_W-1:0] out_temp,
  output logic signed [PRES_W-1:0]  out_pres
);

  logic vld6_r, vld7_r;

  logic signed [PP_W-1:0]   ph_r, ph_nxt;
  logic [PP_W-1:0]          pl_r, pl_nxt;
  logic signed [OFF_W-1:0]  off6_r;
  logic signed [TEMP_W-1:0] temp6_r;

  logic signed [Q_W-1:0]    q;
  logic signed [DIFF_W-1:0] diff;
  logic signed [TEMPO_W-1:0] temp7_r, temp7_nxt;
  logic signed [PRES_W-1:0]  pres7_r, pres7_nxt;

  // stage 6: SENS = hi*2^21 + lo, lo unsigned
  always_comb begin
    pl_nxt = PP_W'(in_s5.d1) * PP_W'(in_s5.sens[SLO_W-1:0]);
    ph_nxt = PP_W'($signed({1'b0, in_s5.d1}))
           * PP_W'($signed(in_s5.sens[OFF_W-1:SLO_W]));
  end

  // stage 7: floor(D1*SENS/2^21) = D1*hi + floor(D1*lo/2^21); then (.. - OFF) >> 15
  always_comb begin
    q         = Q_W'(ph_r) + Q_W'($signed({1'b0, pl_r[PP_W-1:SLO_W]}));
    diff      = DIFF_W'(q) - DIFF_W'(off6_r);
    pres7_nxt = diff[46:15];
    temp7_nxt = temp6_r[TEMPO_W-1:0];
  end

  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    pl_r    <= pl_nxt;
    off6_r  <= in_s5.off;
    temp6_r <= in_s5.temp;
    temp7_r <= temp7_nxt;
    pres7_r <= pres7_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld6_r <= in_vld;
      vld7_r <= vld6_r;
    end
  end

  assign out_vld  = vld7_r;
  assign out_temp = temp7_r;
  assign out_pres = pres7_r;

endmodule

// ===== sim/barometric_pressure_compensation_test.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Loads calibration sets through the register port (reset, datasheet-like,
// all ones, then random sets with extreme words mixed in) and drives raw
// D1/D2 pairs with random gaps. An in-bench integer model predicts the
// temperature and pressure of every accepted pair, and the monitor checks
// each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_test;
  import bpc_pkg::*;

  localparam int NUM_REGS   = 6;
  localparam int RAW_MAX    = (1 << RAW_W) - 1;
  localparam logic [RAW_W-1:0] RAW_FULL = '1;
  localparam int SETTLE_MAX = 1000;

  // indexes past the register file; writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // compensation thresholds in hundredths of a degree
  localparam longint WARM_LIMIT  = 2000;
  localparam longint VCOLD_LIMIT = -1500;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [TEMPO_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0]  pressure_pa;
  } reading_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [RAW_W-1:0]          in_raw_pressure = '0;
  logic [RAW_W-1:0]          in_raw_temperature = '0;
  logic                      out_valid;
  logic signed [TEMPO_W-1:0] out_temperature_centi;
  logic signed [PRES_W-1:0]  out_pressure_pa;
  logic                      cfg_we = 1'b0;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [COEF_W-1:0]         cfg_data = '0;

  // calibration copy, pending pairs and predicted readings
  logic [COEF_W-1:0] cal [NUM_REGS];
  sample_t           samples_pending[$];
  reading_t          readings_due[$];
  sample_t           next_sample;
  reading_t          want;
  int                gap_left;
  int                burst_left;
  int                mismatches = 0;

  barometric_pressure_compensation DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_pa       (out_pressure_pa),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #10 clk = ~clk;

  // second-order compensation of one raw pair with the current calibration
  function automatic reading_t compensate(logic [RAW_W-1:0] d1_raw,
                                          logic [RAW_W-1:0] d2_raw);
    longint   d1, dt, temp, off, sens, t2, sq, off2, sens2, p;
    reading_t r;
    d1   = longint'({40'd0, d1_raw});
    dt   = longint'({40'd0, d2_raw}) - longint'({48'd0, cal[REG_REF_TEMP]}) * 256;
    temp = WARM_LIMIT + ((dt * longint'({48'd0, cal[REG_TEMP_SENS]})) >>> 23);
    off  = longint'({48'd0, cal[REG_OFFSET_COEFF]}) * 65536
         + ((longint'({48'd0, cal[REG_OFFSET_TEMPCO]}) * dt) >>> 7);
    sens = longint'({48'd0, cal[REG_SENS_COEFF]}) * 32768
         + ((longint'({48'd0, cal[REG_SENS_TEMPCO]}) * dt) >>> 8);
    // cold and very cold terms use TEMP before its own correction
    if (temp < WARM_LIMIT) begin
      t2    = (dt * dt) >>> 31;
      sq    = (temp - WARM_LIMIT) * (temp - WARM_LIMIT);
      off2  = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (temp < VCOLD_LIMIT) begin
        sq    = (temp - VCOLD_LIMIT) * (temp - VCOLD_LIMIT);
        off2  = off2 + 7 * sq;
        sens2 = sens2 + ((11 * sq) >>> 1);
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temperature_centi = temp[TEMPO_W-1:0];
    r.pressure_pa       = p[PRES_W-1:0];
    return r;
  endfunction

  // register write; only issued with the pipeline empty
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < NUM_REGS) cal[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
    samples_pending.push_back('{raw_pressure: d1, raw_temperature: d2});
  endtask

  // wait for every pair to transfer and every reading to come back;
  // the driver state is checked mid-cycle, after its updates have settled
  task automatic drain();
    int waited;
    waited = 0;
    while (samples_pending.size() != 0 || start) @(negedge clk);
    while (readings_due.size() != 0 && waited < SETTLE_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (readings_due.size() != 0) begin
      $error("%0d readings never arrived", readings_due.size());
      mismatches++;
      readings_due.delete();
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // driver: one pair per transfer, random gaps with occasional bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        readings_due.push_back(compensate(in_raw_pressure, in_raw_temperature));
      end
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (samples_pending.size() != 0) begin
        next_sample        = samples_pending.pop_front();
        start              <= 1'b1;
        in_raw_pressure    <= next_sample.raw_pressure;
        in_raw_temperature <= next_sample.raw_temperature;
        if (burst_left != 0) begin
          gap_left   <= 0;
          burst_left <= burst_left - 1;
        end else begin
          gap_left <= $urandom_range(0, 10);
          if ($urandom_range(0, 15) == 0) burst_left <= $urandom_range(10, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is a transfer, compared with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (readings_due.size() == 0) begin
        $error("unexpected reading: temperature_centi %0d, pressure_pa %0d",
               out_temperature_centi, out_pressure_pa);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        if (out_temperature_centi !== want.temperature_centi) begin
          $error("temperature_centi mismatch: expected %0d, got %0d",
                 $signed(want.temperature_centi), out_temperature_centi);
          mismatches++;
        end
        if (out_pressure_pa !== want.pressure_pa) begin
          $error("pressure_pa mismatch: expected %0d, got %0d",
                 $signed(want.pressure_pa), out_pressure_pa);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("barometric_pressure_compensation regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    int               ph, n, r, span;
    longint           d2_pick;
    logic [RAW_W-1:0] d1;
    logic [COEF_W-1:0] v;
    for (r = 0; r < NUM_REGS; r++) cal[r] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration still at reset: raw extremes
    queue_sample('0, '0);
    queue_sample(RAW_FULL, RAW_FULL);
    queue_sample('0, RAW_FULL);
    queue_sample(RAW_FULL, '0);
    drain();

    // datasheet-like calibration; spare indexes must not disturb it
    write_reg(REG_SENS_COEFF, 16'd40127);
    write_reg(REG_OFFSET_COEFF, 16'd36924);
    write_reg(REG_SENS_TEMPCO, 16'd23317);
    write_reg(REG_OFFSET_TEMPCO, 16'd23282);
    write_reg(REG_REF_TEMP, 16'd33464);
    write_reg(REG_TEMP_SENS, 16'd28312);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h5A5A);
    queue_sample(24'd9085466, 24'd8569150);   // warm
    queue_sample(24'd9085466, 24'd8566784);   // dT zero, exactly 20.00
    queue_sample(24'd9085466, 24'd8566783);   // just cold
    queue_sample(24'd9085466, 24'd8500000);   // cold
    queue_sample(24'd9085466, 24'd7529764);   // exactly -15.00, cold only
    queue_sample(24'd9085466, 24'd7529763);   // just very cold
    queue_sample(RAW_FULL, '0);               // coldest
    queue_sample('0, RAW_FULL);               // hottest
    drain();

    // every word at its maximum
    for (r = 0; r < NUM_REGS; r++) write_reg(r[IDX_W-1:0], '1);
    queue_sample(RAW_FULL, RAW_FULL);
    queue_sample(RAW_FULL, '0);
    queue_sample('0, '0);
    queue_sample(RAW_FULL, 24'h800000);
    drain();

    // random calibration sets, D2 mostly around the reference reading
    for (ph = 0; ph < 9; ph++) begin
      for (r = 0; r < NUM_REGS; r++) begin
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = '1;
          default: v = COEF_W'($urandom);
        endcase
        write_reg(r[IDX_W-1:0], v);
      end
      if (ph % 3 == 0) write_reg(ph % 2 ? REG_SPARE_LO : REG_SPARE_HI, COEF_W'($urandom));
      for (n = 0; n < 60; n++) begin
        case ($urandom_range(0, 7))
          0:       d1 = '0;
          1:       d1 = RAW_FULL;
          default: d1 = RAW_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: d2_pick = longint'($urandom_range(0, RAW_MAX));
          1: d2_pick = longint'($urandom_range(0, 1 << 20));
          default: begin
            span    = $urandom_range(0, 1) ? (1 << 16) : (1 << 21);
            d2_pick = longint'({48'd0, cal[REG_REF_TEMP]}) * 256
                    + longint'($urandom_range(0, 2 * span)) - longint'(span);
          end
        endcase
        if (d2_pick < 0) d2_pick = 0;
        if (d2_pick > RAW_MAX) d2_pick = longint'(RAW_MAX);
        queue_sample(d1, d2_pick[RAW_W-1:0]);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("barometric_pressure_compensation regression: pass");
    end else begin
      $display("barometric_pressure_compensation regression: fail");
    end
    $finish;
  end

endmodule
